/* rtl/core/pi_heater_drive_unit_assert.svh */
// ----------------------------------------------------------------------------
// PI heater drive assertion macros
// Concurrent checks on clk, disabled while arst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef PI_HEATER_DRIVE_UNIT_ASSERT_SVH
`define PI_HEATER_DRIVE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define PHDU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define PHDU_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define PHDU_ASSERT(lbl, prop, msg)

`define PHDU_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

/* rtl/core/pihd_pkg.sv */
// ----------------------------------------------------------------------------
// PI heater drive package
// Widths, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package pihd_pkg;

	localparam int DUTY_BITS = 10;

	localparam int TEMP_W  = 16;
	localparam int ERR_W   = TEMP_W + 1;
	localparam int SUM_W   = ERR_W + 1;
	localparam int GAIN_W  = 16;
	localparam int TS_W    = 16;
	localparam int LIMIT_W = 48;
	localparam int INTEG_W = LIMIT_W + 1;
	localparam int ISUM_W  = INTEG_W + 1;
	localparam int PROD_W  = INTEG_W + GAIN_W;
	localparam int DLIM_W  = 10;
	localparam int FRAC_W  = 8;
	localparam int ACC_W   = (DUTY_BITS > DLIM_W ? DUTY_BITS : DLIM_W) + FRAC_W;

	localparam int TS_SHIFT = 1;
	localparam int P_SHIFT  = 4;
	localparam int I_SHIFT  = 12;
	localparam int DRV_W    = PROD_W - I_SHIFT + 1;

	localparam int CNT_W = $clog2(GAIN_W);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = LIMIT_W;
	localparam int OUT_W      = ((DUTY_BITS + 2 + 7) / 8) * 8;

	localparam logic [TEMP_W-1:0]  SETPOINT_RST  = '0;
	localparam logic               HEAT_MODE_RST = 1'b1;
	localparam logic [TS_W-1:0]    TIME_STEP_RST = TS_W'(256);
	localparam logic [LIMIT_W-1:0] INT_LIMIT_RST = '1;
	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST = GAIN_W'(256);
	localparam logic [GAIN_W-1:0]  INT_GAIN_RST  = '0;
	localparam logic [DLIM_W-1:0]  DUTY_LIM_RST  = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETPOINT,
		REG_HEAT_MODE,
		REG_TIME_STEP,
		REG_INT_LIMIT,
		REG_PROP_GAIN,
		REG_INT_GAIN,
		REG_DUTY_LIMIT
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL_TS,
		ST_INTEG,
		ST_MUL_P,
		ST_ADD_P,
		ST_MUL_I,
		ST_ADD_I,
		ST_CLAMP
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic mul_step;
		logic out_load;
	} ctrl_t;

endpackage

/* rtl/core/pi_heater_drive_unit.sv */
// ----------------------------------------------------------------------------
// PI heater drive unit
// Each transfer on the slave side carries one temperature sample and yields
// one transfer on the master side with the new PWM duty and two status flags.
// An item goes from its transfer to its result in steps: one shift-add
// multiplier, one multiplier bit per cycle, forms the three products (time
// step, proportional, integral) in turn, with a setup state before the
// first, an add state after each and a final clamp. One item is in work at a
// time; a finished result waits in the output register while the next sample
// is taken. Configuration writes are always taken and belong between items.
// ----------------------------------------------------------------------------
`include "pi_heater_drive_unit_assert.svh"

module pi_heater_drive_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [pihd_pkg::TEMP_W-1:0]            s_tdata,   // [15:0] measured_temp
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [pihd_pkg::OUT_W-1:0]             m_tdata,   // [9:0] duty, [10] integral_clamped,
	                                                           // [11] drive_saturated, zero above
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [pihd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pihd_pkg::CFG_DATA_W-1:0]        cfg_data
);

	pihd_pkg::state_t state_q, state_d;
	pihd_pkg::ctrl_t  ctrl;

	logic signed [pihd_pkg::TEMP_W-1:0]  setpoint_q;
	logic                                heat_mode_q;
	logic [pihd_pkg::TS_W-1:0]           time_step_q;
	logic [pihd_pkg::LIMIT_W-1:0]        int_limit_q;
	logic [pihd_pkg::GAIN_W-1:0]         prop_gain_q;
	logic [pihd_pkg::GAIN_W-1:0]         int_gain_q;
	logic [pihd_pkg::DLIM_W-1:0]         duty_limit_q;

	logic signed [pihd_pkg::ERR_W-1:0]   last_err_q;
	logic signed [pihd_pkg::INTEG_W-1:0] integ_q;
	logic [pihd_pkg::ACC_W-1:0]          acc_q;

	logic signed [pihd_pkg::TEMP_W-1:0]  meas_q;
	logic signed [pihd_pkg::ERR_W-1:0]   err_q;
	logic signed [pihd_pkg::INTEG_W-1:0] mcand_q;
	logic [pihd_pkg::PROD_W-1:0]         prod_q;
	logic [pihd_pkg::CNT_W-1:0]          cnt_q;
	logic signed [pihd_pkg::DRV_W-1:0]   drv_q;
	logic                                iclamp_q;

	logic                                m_tvalid_q;
	logic [pihd_pkg::DUTY_BITS-1:0]      duty_q;
	logic                                iclamp_out_q;
	logic                                dsat_q;

	logic                                out_free;
	logic                                mul_last;
	logic signed [pihd_pkg::ERR_W-1:0]   err_raw;
	logic signed [pihd_pkg::ERR_W-1:0]   err_new;
	logic signed [pihd_pkg::SUM_W-1:0]   sum_new;
	logic signed [pihd_pkg::INTEG_W-1:0] upper;
	logic [pihd_pkg::ISUM_W-1:0]         macc;
	logic signed [pihd_pkg::ISUM_W-1:0]  integ_sum;
	logic                                integ_hi;
	logic                                integ_lo;
	logic signed [pihd_pkg::INTEG_W-1:0] integ_new;
	logic signed [pihd_pkg::DRV_W-1:0]   p_term;
	logic signed [pihd_pkg::DRV_W-1:0]   i_term;
	logic signed [pihd_pkg::DRV_W-1:0]   top;
	logic                                drv_neg;
	logic                                drv_hi;
	logic [pihd_pkg::ACC_W-1:0]          acc_new;

	assign cfg_ready = 1'b1;
	assign s_tready  = ctrl.in_ready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = pihd_pkg::OUT_W'({dsat_q, iclamp_out_q, duty_q});

	assign out_free = !m_tvalid_q || m_tready;
	assign mul_last = (cnt_q == pihd_pkg::CNT_W'(pihd_pkg::GAIN_W - 1));

	// error and trapezoid sum
	assign err_raw = pihd_pkg::ERR_W'(setpoint_q) - pihd_pkg::ERR_W'(meas_q);
	assign err_new = heat_mode_q ? err_raw : -err_raw;
	assign sum_new = pihd_pkg::SUM_W'(last_err_q) + pihd_pkg::SUM_W'(err_new);

	// shift-add step: add multiplicand on the low multiplier bit, shift right
	assign upper = $signed(prod_q[pihd_pkg::PROD_W-1:pihd_pkg::GAIN_W]);
	assign macc  = pihd_pkg::ISUM_W'(upper) +
	               (prod_q[0] ? pihd_pkg::ISUM_W'(mcand_q) : '0);

	// integral update with upper clamp and lower saturation
	assign integ_sum = pihd_pkg::ISUM_W'(integ_q) +
		$signed(prod_q[pihd_pkg::ISUM_W+pihd_pkg::TS_SHIFT-1:pihd_pkg::TS_SHIFT]);
	assign integ_hi = integ_sum > $signed(pihd_pkg::ISUM_W'(int_limit_q));
	assign integ_lo = integ_sum[pihd_pkg::ISUM_W-1] && !integ_sum[pihd_pkg::ISUM_W-2];

	always_comb begin
		priority if (integ_hi) begin
			integ_new = $signed(pihd_pkg::INTEG_W'(int_limit_q));
		end else if (integ_lo) begin
			integ_new = $signed({1'b1, {(pihd_pkg::INTEG_W-1){1'b0}}});
		end else begin
			integ_new = integ_sum[pihd_pkg::INTEG_W-1:0];
		end
	end

	assign p_term = $signed(prod_q[pihd_pkg::DRV_W+pihd_pkg::P_SHIFT-1:pihd_pkg::P_SHIFT]);
	assign i_term = $signed({prod_q[pihd_pkg::PROD_W-1],
	                         prod_q[pihd_pkg::PROD_W-1:pihd_pkg::I_SHIFT]});

	// drive clamp
	assign top     = $signed(pihd_pkg::DRV_W'({duty_limit_q, {pihd_pkg::FRAC_W{1'b0}}}));
	assign drv_neg = drv_q[pihd_pkg::DRV_W-1];
	assign drv_hi  = !drv_neg && (drv_q > top);

	always_comb begin
		priority if (drv_neg) begin
			acc_new = '0;
		end else if (drv_hi) begin
			acc_new = pihd_pkg::ACC_W'({duty_limit_q, {pihd_pkg::FRAC_W{1'b0}}});
		end else begin
			acc_new = drv_q[pihd_pkg::ACC_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pihd_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = pihd_pkg::ST_PREP;
			end
			pihd_pkg::ST_PREP:  state_d = pihd_pkg::ST_MUL_TS;
			pihd_pkg::ST_MUL_TS: begin
				if (mul_last) state_d = pihd_pkg::ST_INTEG;
			end
			pihd_pkg::ST_INTEG: state_d = pihd_pkg::ST_MUL_P;
			pihd_pkg::ST_MUL_P: begin
				if (mul_last) state_d = pihd_pkg::ST_ADD_P;
			end
			pihd_pkg::ST_ADD_P: state_d = pihd_pkg::ST_MUL_I;
			pihd_pkg::ST_MUL_I: begin
				if (mul_last) state_d = pihd_pkg::ST_ADD_I;
			end
			pihd_pkg::ST_ADD_I: state_d = pihd_pkg::ST_CLAMP;
			pihd_pkg::ST_CLAMP: begin
				if (out_free) state_d = pihd_pkg::ST_IDLE;
			end
			default: state_d = pihd_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			pihd_pkg::ST_IDLE:  ctrl.in_ready = 1'b1;
			pihd_pkg::ST_MUL_TS,
			pihd_pkg::ST_MUL_P,
			pihd_pkg::ST_MUL_I: ctrl.mul_step = 1'b1;
			pihd_pkg::ST_CLAMP: ctrl.out_load = out_free;
			default: ctrl = '0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q   <= pihd_pkg::SETPOINT_RST;
			heat_mode_q  <= pihd_pkg::HEAT_MODE_RST;
			time_step_q  <= pihd_pkg::TIME_STEP_RST;
			int_limit_q  <= pihd_pkg::INT_LIMIT_RST;
			prop_gain_q  <= pihd_pkg::PROP_GAIN_RST;
			int_gain_q   <= pihd_pkg::INT_GAIN_RST;
			duty_limit_q <= pihd_pkg::DUTY_LIM_RST;
		end else if (cfg_valid) begin
			case (pihd_pkg::cfg_reg_t'(cfg_index))
				pihd_pkg::REG_SETPOINT:   setpoint_q   <= cfg_data[pihd_pkg::TEMP_W-1:0];
				pihd_pkg::REG_HEAT_MODE:  heat_mode_q  <= cfg_data[0];
				pihd_pkg::REG_TIME_STEP:  time_step_q  <= cfg_data[pihd_pkg::TS_W-1:0];
				pihd_pkg::REG_INT_LIMIT:  int_limit_q  <= cfg_data[pihd_pkg::LIMIT_W-1:0];
				pihd_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_data[pihd_pkg::GAIN_W-1:0];
				pihd_pkg::REG_INT_GAIN:   int_gain_q   <= cfg_data[pihd_pkg::GAIN_W-1:0];
				pihd_pkg::REG_DUTY_LIMIT: duty_limit_q <= cfg_data[pihd_pkg::DLIM_W-1:0];
				default: ;
			endcase
		end
	end

	// control and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pihd_pkg::ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			last_err_q <= '0;
			integ_q    <= '0;
			acc_q      <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.mul_step) cnt_q <= cnt_q + pihd_pkg::CNT_W'(1);
			if (ctrl.out_load) begin
				m_tvalid_q <= 1'b1;
				acc_q      <= acc_new;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (state_q == pihd_pkg::ST_PREP) last_err_q <= err_new;
			if (state_q == pihd_pkg::ST_INTEG) integ_q <= integ_new;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (s_tvalid && ctrl.in_ready) meas_q <= s_tdata;
		if (ctrl.mul_step) begin
			prod_q <= {macc, prod_q[pihd_pkg::GAIN_W-1:1]};
		end
		unique case (state_q)
			pihd_pkg::ST_PREP: begin
				err_q   <= err_new;
				mcand_q <= pihd_pkg::INTEG_W'(sum_new);
				prod_q  <= pihd_pkg::PROD_W'(time_step_q);
			end
			pihd_pkg::ST_INTEG: begin
				iclamp_q <= integ_hi;
				mcand_q  <= pihd_pkg::INTEG_W'(err_q);
				prod_q   <= pihd_pkg::PROD_W'(prop_gain_q);
			end
			pihd_pkg::ST_ADD_P: begin
				drv_q   <= $signed(pihd_pkg::DRV_W'(acc_q)) + p_term;
				mcand_q <= integ_q;
				prod_q  <= pihd_pkg::PROD_W'(int_gain_q);
			end
			pihd_pkg::ST_ADD_I: begin
				drv_q <= drv_q + i_term;
			end
			default: ;
		endcase
		if (ctrl.out_load) begin
			duty_q       <= acc_new[pihd_pkg::DUTY_BITS+pihd_pkg::FRAC_W-1:pihd_pkg::FRAC_W];
			iclamp_out_q <= iclamp_q;
			dsat_q       <= drv_neg || drv_hi;
		end
	end

	`PHDU_ASSERT(a_accept_starts, (s_tvalid && s_tready) |=> (state_q == pihd_pkg::ST_PREP), "transfer in did not start an item")
	`PHDU_ASSERT(a_cnt_idle, (state_q != pihd_pkg::ST_MUL_TS && state_q != pihd_pkg::ST_MUL_P && state_q != pihd_pkg::ST_MUL_I) |-> (cnt_q == '0), "multiplier count not aligned")
	`PHDU_ASSERT(a_integ_limit, (state_q == pihd_pkg::ST_INTEG) |=> (integ_q <= $signed(pihd_pkg::INTEG_W'(int_limit_q))), "integral above its limit")
	`PHDU_ASSERT(a_result_held, (ctrl.out_load) |=> (m_tvalid && (state_q == pihd_pkg::ST_IDLE)), "result not presented")
	`PHDU_ASSERT_NEVER(a_acc_range, acc_q > pihd_pkg::ACC_W'({{pihd_pkg::DLIM_W{1'b1}}, {pihd_pkg::FRAC_W{1'b0}}}), "drive accumulator out of range")

endmodule

/* verif/pi_heater_drive_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI heater drive checker
// Watches the sample, result and register channels of the drive unit. Keeps a
// shadow of the registers and of the loop state, works out the duty and the
// two flags for every accepted sample, and compares each result transfer
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pi_heater_drive_checker
	import pihd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [TEMP_W-1:0]     s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_W-1:0]      m_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    pending,
	output int                    checked,
	output int                    clamps_seen,
	output int                    sats_seen
);

	typedef logic signed [95:0] wide_t;

	typedef struct packed {
		logic [DUTY_BITS-1:0] duty;
		logic                 int_clamp;
		logic                 drive_sat;
	} drive_result_t;

	localparam wide_t INTEG_FLOOR = -(96'sd1 <<< (INTEG_W - 1));

	drive_result_t duty_expect_q[$];

	logic signed [TEMP_W-1:0] setpoint_r;
	logic                     heat_r;
	logic [TS_W-1:0]          step_r;
	logic [LIMIT_W-1:0]       int_limit_r;
	logic [GAIN_W-1:0]        kp_r;
	logic [GAIN_W-1:0]        ki_r;
	logic [DLIM_W-1:0]        duty_lim_r;

	logic signed [SUM_W-1:0]   prev_err;
	logic signed [INTEG_W-1:0] integral_r;
	logic [ACC_W-1:0]          drive_acc;

	int n_bad, n_checked, n_clamps, n_sats;

	initial begin
		n_bad = 0;
		n_checked = 0;
		n_clamps = 0;
		n_sats = 0;
	end

	task automatic report_mismatch(input string what, input longint want, input longint got);
		$display("%0t ns: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
		n_bad++;
	endtask

	task automatic predict_drive(input logic [TEMP_W-1:0] temp);
		wide_t err, meas, sum, inc, integ, p_term, i_term, drive, top;
		wide_t step, lim, kp, ki, acc;
		drive_result_t r;
		step = step_r;
		lim = int_limit_r;
		kp = kp_r;
		ki = ki_r;
		acc = drive_acc;
		top = duty_lim_r;
		top = top <<< FRAC_W;
		r = '0;

		err = setpoint_r;
		meas = $signed(temp);
		err = err - meas;
		if (!heat_r)
			err = -err;

		sum = prev_err + err;
		inc = (step * sum) >>> TS_SHIFT;
		integ = integral_r + inc;
		if (integ > lim) begin
			integ = lim;
			r.int_clamp = 1'b1;
		end
		if (integ < INTEG_FLOOR)
			integ = INTEG_FLOOR;

		p_term = (kp * err) >>> P_SHIFT;
		i_term = (ki * integ) >>> I_SHIFT;
		drive = acc + p_term + i_term;
		if (drive < 0) begin
			drive = 0;
			r.drive_sat = 1'b1;
		end else if (drive > top) begin
			drive = top;
			r.drive_sat = 1'b1;
		end

		drive_acc = drive[ACC_W-1:0];
		integral_r = integ[INTEG_W-1:0];
		prev_err = err[SUM_W-1:0];
		r.duty = drive[FRAC_W +: DUTY_BITS];
		duty_expect_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		drive_result_t want;
		if (!arst_n) begin
			setpoint_r = SETPOINT_RST;
			heat_r = HEAT_MODE_RST;
			step_r = TIME_STEP_RST;
			int_limit_r = INT_LIMIT_RST;
			kp_r = PROP_GAIN_RST;
			ki_r = INT_GAIN_RST;
			duty_lim_r = DUTY_LIM_RST;
			prev_err = '0;
			integral_r = '0;
			drive_acc = '0;
			duty_expect_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (duty_expect_q.size() == 0) begin
					report_mismatch("unexpected result", 0, m_tdata);
				end else begin
					want = duty_expect_q.pop_front();
					if (m_tdata[DUTY_BITS-1:0] !== want.duty)
						report_mismatch("duty", want.duty, m_tdata[DUTY_BITS-1:0]);
					if (m_tdata[DUTY_BITS] !== want.int_clamp)
						report_mismatch("integral_clamped", want.int_clamp, m_tdata[DUTY_BITS]);
					if (m_tdata[DUTY_BITS+1] !== want.drive_sat)
						report_mismatch("drive_saturated", want.drive_sat, m_tdata[DUTY_BITS+1]);
					if (m_tdata[OUT_W-1:DUTY_BITS+2] !== '0)
						report_mismatch("padding", 0, m_tdata[OUT_W-1:DUTY_BITS+2]);
					n_checked++;
					n_clamps += want.int_clamp;
					n_sats += want.drive_sat;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_SETPOINT:   setpoint_r = cfg_data[TEMP_W-1:0];
					REG_HEAT_MODE:  heat_r = cfg_data[0];
					REG_TIME_STEP:  step_r = cfg_data[TS_W-1:0];
					REG_INT_LIMIT:  int_limit_r = cfg_data[LIMIT_W-1:0];
					REG_PROP_GAIN:  kp_r = cfg_data[GAIN_W-1:0];
					REG_INT_GAIN:   ki_r = cfg_data[GAIN_W-1:0];
					REG_DUTY_LIMIT: duty_lim_r = cfg_data[DLIM_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_drive(s_tdata);
		end
		mismatches <= n_bad;
		pending <= duty_expect_q.size();
		checked <= n_checked;
		clamps_seen <= n_clamps;
		sats_seen <= n_sats;
	end

endmodule

/* verif/pi_heater_drive_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI heater drive unit testbench
// Drives temperature samples and register writes into the drive unit with
// random gaps and result back-pressure. A directed run covers field extremes,
// both modes, integral and drive clamping and lowered limits; random register
// settings follow, each with a burst of samples near or far from setpoint.
// ----------------------------------------------------------------------------
module pi_heater_drive_unit_test;
	import pihd_pkg::*;

	localparam int LATENCY      = 53;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 500;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = '1;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [TEMP_W-1:0]     s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches, pending, checked, clamps_seen, sats_seen;
	int cycles = 0;
	int samples = 0;
	int settings = 0;
	int send_calm = 0;
	int recv_calm = 0;
	logic [TEMP_W-1:0] cur_setpoint;

	always #10 clk = ~clk;

	pi_heater_drive_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pi_heater_drive_checker drive_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.pending     (pending),
		.checked     (checked),
		.clamps_seen (clamps_seen),
		.sats_seen   (sats_seen)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// hold valid across back-to-back writes; end_writes drops it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic end_writes();
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic send_temp(input logic [TEMP_W-1:0] temp);
		int gap;
		if (send_calm > 0) begin
			gap = 0;
			send_calm--;
		end else begin
			if ($urandom_range(0, 19) == 0)
				send_calm = $urandom_range(5, 25);
			gap = $urandom_range(0, 10);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= temp;
		do @(posedge clk); while (!s_tready);
		samples++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (recv_calm > 0) begin
				stall = 0;
				recv_calm--;
			end else begin
				if ($urandom_range(0, 19) == 0)
					recv_calm = $urandom_range(5, 25);
				stall = $urandom_range(0, 10);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		logic [LIMIT_W-1:0] junk;
		logic [TEMP_W-1:0]  temp;
		logic [TS_W-1:0]    step;
		logic [LIMIT_W-1:0] lim;
		logic [GAIN_W-1:0]  kp, ki;
		logic [DLIM_W-1:0]  dlim;
		int random_sent, burst;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cur_setpoint = SETPOINT_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: full-scale errors both ways, then small steps
		send_temp(16'h0000);
		send_temp(16'h8000);
		send_temp(16'h7FFF);
		send_temp(16'h0010);
		send_temp(16'hFFF0);
		drain();

		// large integral steps against a modest limit
		write_reg(REG_SETPOINT, 48'h7FFF);
		write_reg(REG_TIME_STEP, 48'hFFFF);
		write_reg(REG_INT_GAIN, 48'd256);
		write_reg(REG_PROP_GAIN, 48'd16);
		write_reg(REG_INT_LIMIT, 48'd1_000_000_000);
		end_writes();
		cur_setpoint = 16'h7FFF;
		repeat (3) send_temp(16'h8000);
		drain();

		// limit lowered under the stored integral with no increment
		write_reg(REG_TIME_STEP, '0);
		write_reg(REG_INT_LIMIT, '0);
		end_writes();
		send_temp(16'h7FFF);
		drain();

		// cooling mode, all gains and step at full scale
		write_reg(REG_HEAT_MODE, '0);
		write_reg(REG_SETPOINT, 48'h8000);
		write_reg(REG_TIME_STEP, 48'hFFFF);
		write_reg(REG_INT_LIMIT, '1);
		write_reg(REG_PROP_GAIN, 48'hFFFF);
		write_reg(REG_INT_GAIN, 48'hFFFF);
		end_writes();
		cur_setpoint = 16'h8000;
		send_temp(16'h7FFF);
		send_temp(16'h8000);
		send_temp(16'h0000);
		send_temp(16'hFFFF);
		drain();

		// duty limit lowered under the stored drive; unused index ignored
		write_reg(REG_PROP_GAIN, '0);
		write_reg(REG_INT_GAIN, '0);
		write_reg(REG_DUTY_LIMIT, 48'd100);
		write_reg(REG_NONE, 48'hFFFF_FFFF_FFFF);
		end_writes();
		send_temp(16'h1234);
		drain();
		write_reg(REG_DUTY_LIMIT, '0);
		end_writes();
		send_temp(16'h4321);
		drain();

		// zero time step, unit gains
		write_reg(REG_HEAT_MODE, 48'd1);
		write_reg(REG_SETPOINT, '0);
		write_reg(REG_TIME_STEP, '0);
		write_reg(REG_PROP_GAIN, 48'd1);
		write_reg(REG_INT_GAIN, 48'd1);
		write_reg(REG_DUTY_LIMIT, 48'd1023);
		end_writes();
		cur_setpoint = '0;
		send_temp(16'h0001);
		send_temp(16'h5555);
		send_temp(16'hAAAA);
		drain();

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			junk = LIMIT_W'({$urandom, $urandom});
			case ($urandom_range(0, 3))
				0: cur_setpoint = 16'h8000;
				1: cur_setpoint = 16'h7FFF;
				default: cur_setpoint = $urandom;
			endcase
			case ($urandom_range(0, 3))
				0: step = '0;
				1: step = '1;
				2: step = $urandom_range(1, 1023);
				default: step = $urandom;
			endcase
			case ($urandom_range(0, 3))
				0: lim = '0;
				1: lim = '1;
				2: lim = LIMIT_W'($urandom_range(0, 1 << 20));
				default: lim = LIMIT_W'({$urandom, $urandom});
			endcase
			case ($urandom_range(0, 3))
				0: kp = '0;
				1: kp = '1;
				default: kp = $urandom_range(0, 1023);
			endcase
			case ($urandom_range(0, 3))
				0: ki = '0;
				1: ki = '1;
				default: ki = $urandom_range(0, 255);
			endcase
			case ($urandom_range(0, 3))
				0: dlim = '0;
				1: dlim = '1;
				default: dlim = $urandom;
			endcase
			write_reg(REG_SETPOINT, {junk[LIMIT_W-1:TEMP_W], cur_setpoint});
			write_reg(REG_HEAT_MODE, {junk[LIMIT_W-1:1], 1'($urandom_range(0, 1))});
			write_reg(REG_TIME_STEP, {junk[LIMIT_W-1:TS_W], step});
			write_reg(REG_INT_LIMIT, lim);
			write_reg(REG_PROP_GAIN, {junk[LIMIT_W-1:GAIN_W], kp});
			write_reg(REG_INT_GAIN, {junk[LIMIT_W-1:GAIN_W], ki});
			write_reg(REG_DUTY_LIMIT, {junk[LIMIT_W-1:DLIM_W], dlim});
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_NONE, junk);
			end_writes();

			burst = $urandom_range(10, 50);
			repeat (burst) begin
				case ($urandom_range(0, 3))
					0: temp = $urandom;
					1: temp = cur_setpoint + TEMP_W'($urandom_range(0, 4095)) - TEMP_W'(2048);
					default: temp = cur_setpoint + TEMP_W'($urandom_range(0, 63)) - TEMP_W'(32);
				endcase
				send_temp(temp);
			end
			random_sent += burst;
			drain();
		end

		repeat (LATENCY + 10) @(posedge clk);
		$display("sent %0d temperature samples over %0d register settings, %0d results checked",
			samples, settings, checked);
		$display("integral clamps seen %0d, drive saturations seen %0d", clamps_seen, sats_seen);
		if (mismatches == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/pihd_pkg.sv
rtl/core/pi_heater_drive_unit.sv
verif/pi_heater_drive_checker.sv
verif/pi_heater_drive_unit_test.sv
